>>> rtl/ryuv_pkg.sv
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// No dependencies; used by ryuv_line_buf and rgb_to_yuv420_converter.
package ryuv_pkg;

    localparam int CFG_W       = 10;
    localparam int LINE_W_RST  = 400;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 9;

    // BT.601 integer coefficients
    localparam int Y_R         = 66;
    localparam int Y_G         = 129;
    localparam int Y_B         = 25;
    localparam int CB_R        = -38;
    localparam int CB_G        = -74;
    localparam int CB_B        = 112;
    localparam int CR_R        = 112;
    localparam int CR_G        = -94;
    localparam int CR_B        = -18;
    localparam int ROUND       = 128;
    localparam int LUMA_OFS    = 16;
    localparam int CHROMA_OFS  = 128;
    localparam int BYTE_MAX    = 255;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_pair_sum;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_pixel;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_lb_req;

    function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [9:0] v);
        logic [PIX_W-1:0] res;
        if (v < 10'sd0) begin
            res = '0;
        end else if (v > 10'(BYTE_MAX)) begin
            res = PIX_W'(BYTE_MAX);
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/ryuv_line_buf.sv
// Line buffer of even-row pair sums: one write and one read per cycle,
// read data registered. Depends on ryuv_pkg.
module ryuv_line_buf #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  ryuv_pkg::t_lb_req   i_req,
    input  logic [AW-1:0]       i_addr,
    input  ryuv_pkg::t_pair_sum i_wdata,
    output ryuv_pkg::t_pair_sum o_rdata
);

    ryuv_pkg::t_pair_sum r_mem [DEPTH];
    ryuv_pkg::t_pair_sum r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rgb_to_yuv420_converter.sv
// RGB to YUV 4:2:0 (BT.601 integer) pixel-stream converter, top level.
// Registered through stage 1, stage 2 and output; one pixel per clock unless a held o_valid stalls the pipe.
// Stage 1 takes the line buffer's registered read data; stages 1 and 2 hold the
// constant multiply-adds for luma/averages and for Cb/Cr.
// Reset (sync, active low): column, row parity, held pixel, valids cleared,
// line_width = 400. Line buffer contents are not cleared.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ryuv_pkg::CFG_W-1:0]   i_cfg_line_width,
    // pixel in
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_red,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_green,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_blue,
    input  logic                         i_start_of_frame,
    // result out
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ryuv_pkg::PIX_W-1:0]   o_luma,
    output logic [ryuv_pkg::PIX_W-1:0]   o_chroma_blue,
    output logic [ryuv_pkg::PIX_W-1:0]   o_chroma_red,
    output logic                         o_chroma_valid
);

    localparam int COLW  = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (COLW > ryuv_pkg::CFG_W) ? COLW : ryuv_pkg::CFG_W;
    localparam logic [WW-1:0] MAX_EVEN = WW'(MAX_WIDTH - (MAX_WIDTH % 2));

    // ---------------- configuration ----------------
    logic [ryuv_pkg::CFG_W-1:0] r_line_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= ryuv_pkg::CFG_W'(ryuv_pkg::LINE_W_RST);
        end else if (i_cfg_valid) begin
            r_line_width <= i_cfg_line_width;
        end
    end

    logic [WW-1:0] w_req;
    logic [WW-1:0] eff_width;

    assign w_req     = WW'({r_line_width[ryuv_pkg::CFG_W-1:1], 1'b0});
    assign eff_width = (w_req == '0 || w_req > MAX_EVEN) ? MAX_EVEN : w_req;

    // ---------------- pipeline enable ----------------
    logic r_o_valid;
    logic en;
    logic accept;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;

    // ---------------- stage 0: position, pair sums, line buffer access ----------------
    logic [COLW-1:0]     r_col;
    logic                r_row;
    ryuv_pkg::t_pixel    r_held;

    logic [COLW-1:0]     col_cur;
    logic                row_cur;
    logic [WW-1:0]       col_inc;
    logic                wrap;
    logic [COLW-1:0]     col_half;
    logic [AW-1:0]       lb_addr;
    ryuv_pkg::t_pair_sum pair_sum;
    ryuv_pkg::t_lb_req   lb_req;
    ryuv_pkg::t_pair_sum lb_rdata;

    assign col_cur  = i_start_of_frame ? '0 : r_col;
    assign row_cur  = i_start_of_frame ? 1'b0 : r_row;
    assign col_inc  = WW'(col_cur) + WW'(1);
    assign wrap     = col_inc >= eff_width;
    assign col_half = col_cur >> 1;
    assign lb_addr  = (col_half >= COLW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(col_half);

    assign pair_sum.r = ryuv_pkg::SUM_W'(r_held.r) + ryuv_pkg::SUM_W'(i_red);
    assign pair_sum.g = ryuv_pkg::SUM_W'(r_held.g) + ryuv_pkg::SUM_W'(i_green);
    assign pair_sum.b = ryuv_pkg::SUM_W'(r_held.b) + ryuv_pkg::SUM_W'(i_blue);

    // even row stores the pair sum, odd row fetches it; the two accesses to an
    // entry are always at least two requests apart, so no forwarding is needed
    assign lb_req.wr = accept && col_cur[0] && !row_cur;
    assign lb_req.rd = accept && col_cur[0] && row_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= 1'b0;
            r_held <= '0;
        end else if (accept) begin
            r_col <= wrap ? '0 : col_inc[COLW-1:0];
            r_row <= wrap ? !row_cur : row_cur;
            if (!col_cur[0]) begin
                r_held <= '{r: i_red, g: i_green, b: i_blue};
            end
        end
    end

    ryuv_line_buf #(
        .DEPTH(DEPTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_req   (lb_req),
        .i_addr  (lb_addr),
        .i_wdata (pair_sum),
        .o_rdata (lb_rdata)
    );

    // ---------------- stage 1: luma, block averages ----------------
    logic                r_s1_valid;
    logic                r_s1_chroma;
    ryuv_pkg::t_pixel    r_s1_pix;
    ryuv_pkg::t_pair_sum r_s1_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_chroma <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= accept;
            r_s1_chroma <= lb_req.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix <= '{r: i_red, g: i_green, b: i_blue};
            r_s1_sum <= pair_sum;
        end
    end

    logic [15:0]                y_acc;
    logic signed [9:0]          y_pre;
    logic [ryuv_pkg::PIX_W-1:0] n_luma1;
    ryuv_pkg::t_pixel           n_avg;

    assign y_acc = 16'(ryuv_pkg::Y_R * r_s1_pix.r + ryuv_pkg::Y_G * r_s1_pix.g
                     + ryuv_pkg::Y_B * r_s1_pix.b + ryuv_pkg::ROUND);
    assign y_pre   = $signed({2'b00, y_acc[15:8]}) + 10'(ryuv_pkg::LUMA_OFS);
    assign n_luma1 = ryuv_pkg::clamp_byte(y_pre);

    assign n_avg.r = 8'((10'(r_s1_sum.r) + 10'(lb_rdata.r)) >> 2);
    assign n_avg.g = 8'((10'(r_s1_sum.g) + 10'(lb_rdata.g)) >> 2);
    assign n_avg.b = 8'((10'(r_s1_sum.b) + 10'(lb_rdata.b)) >> 2);

    // ---------------- stage 2: Cb / Cr ----------------
    logic                       r_s2_valid;
    logic                       r_s2_chroma;
    logic [ryuv_pkg::PIX_W-1:0] r_s2_luma;
    ryuv_pkg::t_pixel           r_s2_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s2_chroma <= 1'b0;
        end else if (en) begin
            r_s2_valid  <= r_s1_valid;
            r_s2_chroma <= r_s1_chroma && r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_luma <= n_luma1;
            r_s2_avg  <= n_avg;
        end
    end

    logic signed [8:0]  ar;
    logic signed [8:0]  ag;
    logic signed [8:0]  ab;
    logic signed [16:0] cb_acc;
    logic signed [16:0] cr_acc;
    logic signed [16:0] cb_sh;
    logic signed [16:0] cr_sh;
    logic signed [9:0]  cb_pre;
    logic signed [9:0]  cr_pre;

    assign ar = $signed({1'b0, r_s2_avg.r});
    assign ag = $signed({1'b0, r_s2_avg.g});
    assign ab = $signed({1'b0, r_s2_avg.b});

    assign cb_acc = 17'(ryuv_pkg::CB_R * ar + ryuv_pkg::CB_G * ag
                      + ryuv_pkg::CB_B * ab + ryuv_pkg::ROUND);
    assign cr_acc = 17'(ryuv_pkg::CR_R * ar + ryuv_pkg::CR_G * ag
                      + ryuv_pkg::CR_B * ab + ryuv_pkg::ROUND);
    assign cb_sh  = cb_acc >>> 8;
    assign cr_sh  = cr_acc >>> 8;
    assign cb_pre = 10'(cb_sh) + 10'(ryuv_pkg::CHROMA_OFS);
    assign cr_pre = 10'(cr_sh) + 10'(ryuv_pkg::CHROMA_OFS);

    // ---------------- output register ----------------
    logic [ryuv_pkg::PIX_W-1:0] r_o_luma;
    logic [ryuv_pkg::PIX_W-1:0] r_o_cb;
    logic [ryuv_pkg::PIX_W-1:0] r_o_cr;
    logic                       r_o_cvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_luma   <= r_s2_luma;
            r_o_cb     <= r_s2_chroma ? ryuv_pkg::clamp_byte(cb_pre) : '0;
            r_o_cr     <= r_s2_chroma ? ryuv_pkg::clamp_byte(cr_pre) : '0;
            r_o_cvalid <= r_s2_chroma;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_luma         = r_o_luma;
    assign o_chroma_blue  = r_o_cb;
    assign o_chroma_red   = r_o_cr;
    assign o_chroma_valid = r_o_cvalid;

    // ---------------- assertions ----------------
    a_lb_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lb_req.wr && lb_req.rd))
        else $error("line buffer read and write in the same cycle");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < MAX_EVEN)
        else $error("column counter out of range");

    a_chroma_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_chroma |-> r_s2_valid)
        else $error("chroma flag on an empty stage");

    a_read_feeds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lb_req.rd |=> (r_s1_valid && r_s1_chroma))
        else $error("line buffer read not followed by a chroma item in stage 1");

endmodule
